@@ rtl/core/klt_pkg.sv @@
// Shared types, constants and keyword tables for the keyword lexer.
`default_nettype none
package klt_pkg;

  // Offset counter width and token length limit.
  localparam int OFFSET_BITS   = 16;
  localparam int MAX_TOKEN_LEN = 255;
  localparam int LEN_BITS      = $clog2(MAX_TOKEN_LEN + 1);

  // Token queue between scanner and output side.
  localparam int Q_DEPTH     = 4;
  localparam int Q_PTR_BITS  = $clog2(Q_DEPTH);
  localparam int Q_CNT_BITS  = $clog2(Q_DEPTH + 1);

  // Token kinds.
  localparam logic [2:0] KIND_KEYWORD = 3'd0;
  localparam logic [2:0] KIND_IDENT   = 3'd1;
  localparam logic [2:0] KIND_INT     = 3'd2;
  localparam logic [2:0] KIND_FLOAT   = 3'd3;
  localparam logic [2:0] KIND_OP      = 3'd4;
  localparam logic [2:0] KIND_PUNCT   = 3'd5;
  localparam logic [2:0] KIND_UNKNOWN = 3'd6;

  // Characters with special meaning.
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;

  // Keywords: int, float, if, else, while, return (index order).
  localparam int KW_COUNT = 6;
  localparam int KW_LEN [0:5] = '{3, 5, 2, 4, 5, 6};
  localparam logic [7:0] KW_TEXT [0:5][0:7] = '{
    '{"i", "n", "t", 8'd0, 8'd0, 8'd0, 8'd0, 8'd0},
    '{"f", "l", "o", "a", "t", 8'd0, 8'd0, 8'd0},
    '{"i", "f", 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0},
    '{"e", "l", "s", "e", 8'd0, 8'd0, 8'd0, 8'd0},
    '{"w", "h", "i", "l", "e", 8'd0, 8'd0, 8'd0},
    '{"r", "e", "t", "u", "r", "n", 8'd0, 8'd0}
  };

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] start;
    logic [7:0]  len;
    logic [2:0]  kwi;
    logic [7:0]  ch;
    logic        clip;
    logic        last;
  } token_t;

  // Up to two tokens per accepted byte, in order.
  typedef struct packed {
    logic [1:0] cnt;
    token_t     slot0;
    token_t     slot1;
  } push_t;

  // Keep keywords whose character at pos matches c.
  function automatic logic [5:0] kw_narrow(logic [5:0] cand, logic [LEN_BITS-1:0] pos,
                                           logic [7:0] c);
    logic [31:0] p;
    logic [5:0]  res;
    p   = 32'(pos);
    res = '0;
    for (int i = 0; i < KW_COUNT; i++) begin
      if (cand[i] && (p < 32'(KW_LEN[i])) && (KW_TEXT[i][p[2:0]] == c)) res[i] = 1'b1;
    end
    return res;
  endfunction

  function automatic logic [15:0] off16(logic [OFFSET_BITS-1:0] off);
    logic [31:0] w;
    w = 32'(off);
    return w[15:0];
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/klt_scan.sv @@
// Front end: byte classification, token state and token record assembly.
`default_nettype none
module klt_scan (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          fire,
  input  wire logic [7:0]    text_byte,
  input  wire logic          end_of_text,
  output klt_pkg::push_t     push
);
  import klt_pkg::*;

  localparam logic [1:0] MODE_IDLE = 2'd0;
  localparam logic [1:0] MODE_WORD = 2'd1;
  localparam logic [1:0] MODE_NUM  = 2'd2;

  logic [1:0]             mode, mode_next;
  logic                   seen_dot, seen_dot_next;
  logic [OFFSET_BITS-1:0] byte_offset, byte_offset_next;
  logic [OFFSET_BITS-1:0] token_start, token_start_next;
  logic [LEN_BITS-1:0]    run_length, run_length_next;
  logic [5:0]             keyword_candidates, keyword_candidates_next;
  logic                   length_overflowed, length_overflowed_next;

  logic   is_alpha, is_digit, is_space, is_op, is_punct;
  logic   ext_ok, flush1, sym, flush2;
  token_t rec_a, rec_b, sym_rec;

  // Word or number token from a given scanner state.
  function automatic token_t flush_rec(logic [1:0] md, logic dot, logic [5:0] cand,
                                       logic [LEN_BITS-1:0] len, logic ovf,
                                       logic [OFFSET_BITS-1:0] start);
    token_t      r;
    logic [31:0] lv;
    lv      = 32'(len);
    r       = '0;
    r.start = off16(start);
    r.len   = lv[7:0];
    r.clip  = ovf;
    if (md == MODE_WORD) begin
      r.kind = KIND_IDENT;
      if (!ovf) begin
        for (int i = 0; i < KW_COUNT; i++) begin
          if (cand[i] && (lv == 32'(KW_LEN[i]))) begin
            r.kind = KIND_KEYWORD;
            r.kwi  = 3'(i);
          end
        end
      end
    end else begin
      r.kind = dot ? KIND_FLOAT : KIND_INT;
    end
    return r;
  endfunction

  always_comb begin
    is_alpha = ((text_byte >= "a") && (text_byte <= "z")) ||
               ((text_byte >= "A") && (text_byte <= "Z"));
    is_digit = (text_byte >= "0") && (text_byte <= "9");
    is_space = (text_byte == CH_SPACE) || (text_byte == CH_TAB) ||
               (text_byte == CH_LF) || (text_byte == CH_CR);
    is_op    = (text_byte == CH_PLUS) || (text_byte == CH_MINUS) ||
               (text_byte == CH_STAR) || (text_byte == CH_SLASH);
    is_punct = (text_byte == CH_LPAREN) || (text_byte == CH_RPAREN) ||
               (text_byte == CH_LBRACE) || (text_byte == CH_RBRACE) ||
               (text_byte == CH_SEMI);

    ext_ok = ((mode == MODE_WORD) && (is_alpha || is_digit)) ||
             ((mode == MODE_NUM) && (is_digit || ((text_byte == CH_DOT) && !seen_dot)));
    flush1 = (mode != MODE_IDLE) && !ext_ok;
    rec_a  = flush_rec(mode, seen_dot, keyword_candidates, run_length,
                       length_overflowed, token_start);

    mode_next               = mode;
    seen_dot_next           = seen_dot;
    token_start_next        = token_start;
    run_length_next         = run_length;
    keyword_candidates_next = keyword_candidates;
    length_overflowed_next  = length_overflowed;
    sym                     = 1'b0;

    if (ext_ok) begin
      if (mode == MODE_WORD) begin
        keyword_candidates_next = length_overflowed ? 6'd0 :
                                  kw_narrow(keyword_candidates, run_length, text_byte);
      end
      if (mode == MODE_NUM && text_byte == CH_DOT) seen_dot_next = 1'b1;
      if (run_length < LEN_BITS'(MAX_TOKEN_LEN)) begin
        run_length_next = run_length + LEN_BITS'(1);
      end else begin
        length_overflowed_next = 1'b1;
      end
    end else begin
      mode_next = MODE_IDLE;
      if (is_alpha || is_digit) begin
        mode_next               = is_alpha ? MODE_WORD : MODE_NUM;
        token_start_next        = byte_offset;
        run_length_next         = LEN_BITS'(1);
        length_overflowed_next  = 1'b0;
        seen_dot_next           = 1'b0;
        keyword_candidates_next = is_alpha ? kw_narrow(6'h3F, '0, text_byte) : 6'd0;
      end else if (!is_space) begin
        sym = 1'b1;
      end
    end

    sym_rec       = '0;
    sym_rec.kind  = is_op ? KIND_OP : (is_punct ? KIND_PUNCT : KIND_UNKNOWN);
    sym_rec.start = off16(byte_offset);
    sym_rec.len   = 8'd1;
    sym_rec.ch    = text_byte;

    // End of text flushes whatever token is open after this byte.
    flush2 = end_of_text && (mode_next != MODE_IDLE);
    rec_b  = sym ? sym_rec :
             flush_rec(mode_next, seen_dot_next, keyword_candidates_next, run_length_next,
                       length_overflowed_next, token_start_next);
    rec_b.last = 1'b1;

    push.cnt   = fire ? (2'(flush1) + 2'(sym || flush2)) : 2'd0;
    push.slot0 = flush1 ? rec_a : rec_b;
    push.slot0.last = !(flush1 && (sym || flush2));
    push.slot1 = rec_b;

    if (end_of_text) begin
      mode_next        = MODE_IDLE;
      byte_offset_next = '0;
    end else begin
      byte_offset_next = byte_offset + OFFSET_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode               <= MODE_IDLE;
      seen_dot           <= 1'b0;
      byte_offset        <= '0;
      token_start        <= '0;
      run_length         <= '0;
      keyword_candidates <= '0;
      length_overflowed  <= 1'b0;
    end else if (fire) begin
      mode               <= mode_next;
      seen_dot           <= seen_dot_next;
      byte_offset        <= byte_offset_next;
      token_start        <= token_start_next;
      run_length         <= run_length_next;
      keyword_candidates <= keyword_candidates_next;
      length_overflowed  <= length_overflowed_next;
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/klt_queue.sv @@
// Back end: token queue with two-entry push and one-entry pop to the output.
`default_nettype none
module klt_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire klt_pkg::push_t push,
  output logic                room,
  output logic                out_valid,
  input  wire logic           out_ready,
  output klt_pkg::token_t     head
);
  import klt_pkg::*;

  token_t                entries [0:Q_DEPTH-1];
  logic [Q_PTR_BITS-1:0] wr_ptr, rd_ptr;
  logic [Q_CNT_BITS-1:0] count;
  logic                  pop;
  logic [Q_PTR_BITS-1:0] wr_ptr1;

  assign room      = count <= Q_CNT_BITS'(Q_DEPTH - 2);
  assign out_valid = count != '0;
  assign head      = entries[rd_ptr];
  assign pop       = out_valid && out_ready;
  assign wr_ptr1   = wr_ptr + Q_PTR_BITS'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + Q_PTR_BITS'(push.cnt);
      if (pop) rd_ptr <= rd_ptr + Q_PTR_BITS'(1);
      count  <= count + Q_CNT_BITS'(push.cnt) - Q_CNT_BITS'(pop);
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < Q_DEPTH; i++) begin
      if (push.cnt != 2'd0 && Q_PTR_BITS'(i) == wr_ptr) begin
        entries[i] <= push.slot0;
      end else if (push.cnt == 2'd2 && Q_PTR_BITS'(i) == wr_ptr1) begin
        entries[i] <= push.slot1;
      end
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/keyword_lexer_tokenizer.sv @@
// Top level of the streaming keyword lexer: scanner front end and token queue.
`default_nettype none
// Streaming lexer: one text byte per transfer in, one token per transfer out.
// Bytes are taken at one per cycle; each byte yields zero, one or two tokens
// (a pending word or number, then a symbol or the end-of-text flush). The
// scanner classifies the byte and updates its token state in the same cycle
// it is accepted, pushing finished tokens into a 4-entry queue whose head
// drives the output ports. in_ready drops only when the queue has fewer than
// two free entries. A byte that yields two tokens always leaves the scanner
// idle, so with the output always ready the queue never holds more than two
// tokens and input runs at one byte per cycle; input stalls only while the
// output side stalls.
// A byte's tokens are registered in the queue and shown once at its head.
// Offsets wrap at 2^16; offset returns to 0 after a byte marked end_of_text.
// Token lengths saturate at 255 with length_clipped set; a clipped word is
// never reported as a keyword. Keyword index: int, float, if, else, while,
// return. No configuration registers; no memory clearing after reset.
module keyword_lexer_tokenizer (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  text_byte,
  input  wire logic        end_of_text,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       token_kind,
  output logic [15:0]      start_offset,
  output logic [7:0]       token_length,
  output logic [2:0]       keyword_index,
  output logic [7:0]       char_code,
  output logic             length_clipped,
  output logic             last_of_run
);
  import klt_pkg::*;

  logic   in_fire;
  logic   room;
  push_t  push;
  token_t head;

  // Input transfer whenever the queue can take the worst case of two tokens.
  assign in_ready = room;
  assign in_fire  = in_valid && in_ready;

  klt_scan u_scan (
    .clk         (clk),
    .rst         (rst),
    .fire        (in_fire),
    .text_byte   (text_byte),
    .end_of_text (end_of_text),
    .push        (push)
  );

  klt_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .head      (head)
  );

  // Output fields come straight from the queue head register.
  assign token_kind     = head.kind;
  assign start_offset   = head.start;
  assign token_length   = head.len;
  assign keyword_index  = head.kwi;
  assign char_code      = head.ch;
  assign length_clipped = head.clip;
  assign last_of_run    = head.last;

endmodule
`default_nettype wire
